@@ src/swm_pkg.sv @@
package swm_pkg;

   localparam int SampleWidth = 32;
   localparam int WsizeWidth  = 7;
   localparam logic [WsizeWidth-1:0] WsizeReset = 7'd3;

   // csr register indexes
   localparam logic RegWindowSize = 1'b0;

   // per-cell control; step, restart and the shift flags are shared by every cell of the row
   typedef struct packed {
      logic step;        // a word is taken in this cycle
      logic restart;     // the word opens a new sequence
      logic shift_up;    // realign towards the old end (window shrinks)
      logic shift_down;  // realign towards the new end (window grows)
      logic at_head;     // this cell is where a new word enters
      logic below_head;  // this cell lies before the entry point
   } swm_ctl_type;

endpackage

@@ src/swm_cell.sv @@
module swm_cell
   import swm_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  swm_ctl_type                   ctl,
   input  logic signed [SampleWidth-1:0] sample,
   input  logic signed [SampleWidth-1:0] lo_max,
   input  logic                          lo_live,
   input  logic signed [SampleWidth-1:0] hi_max,
   input  logic                          hi_live,
   output logic signed [SampleWidth-1:0] max_out,
   output logic                          live_out,
   output logic signed [SampleWidth-1:0] max_next
);

   // running maximum over the live words from the entry point up to this cell
   logic signed [SampleWidth-1:0] max_ff;
   logic signed [SampleWidth-1:0] max_in;
   logic                          live_ff;
   logic                          live_in;

   always_comb begin
      max_in  = max_ff;
      live_in = live_ff;
      if (ctl.step) begin
         if (ctl.below_head) begin
            live_in = 1'b0;
         end else if (ctl.at_head) begin
            max_in  = sample;
            live_in = 1'b1;
         end else begin
            // older words survive unless a restart cleared them
            if (lo_live && !ctl.restart && (lo_max > sample)) begin
               max_in = lo_max;
            end else begin
               max_in = sample;
            end
            live_in = 1'b1;
         end
      end else if (ctl.shift_up) begin
         max_in  = lo_max;
         live_in = lo_live;
      end else if (ctl.shift_down) begin
         max_in  = hi_max;
         live_in = hi_live;
      end
   end

   always_ff @(posedge clock) begin
      max_ff <= max_in;
      if (reset) begin
         live_ff <= 1'b0;
      end else begin
         live_ff <= live_in;
      end
   end

   assign max_out  = max_ff;
   assign live_out = live_ff;
   assign max_next = max_in;

endmodule

@@ src/sliding_window_maximum_unit.sv @@
// the result for an accepted word appears in the output register in the next cycle
// throughput: one word per cycle while req_ready is high; every cell of the row updates at once
// after a window_size write the row realigns one cell a cycle, holding req_ready low
//   until it is aligned; only then is the next word taken
// reset (synchronous): window_size 3, row empty, fill count zero, no result held
module sliding_window_maximum_unit
   import swm_pkg::*;
#(
   parameter int MAX_WINDOW = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SampleWidth-1:0] req_sample,
   input  logic                          req_restart,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SampleWidth-1:0] rsp_window_max,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [2:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   localparam int IdxW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CntW   = $clog2(MAX_WINDOW + 1);
   localparam int WideW  = (CntW > WsizeWidth) ? CntW : WsizeWidth;
   localparam int RstWin = (int'(WsizeReset) > MAX_WINDOW) ? MAX_WINDOW : int'(WsizeReset);
   localparam int RstHead = MAX_WINDOW - RstWin;

   // csr
   logic [WsizeWidth-1:0] wsize_ff;
   logic [WsizeWidth-1:0] wsize_in;
   logic                  csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr[2] == RegWindowSize);
   assign prdata    = (paddr[2] == RegWindowSize) ? {{(32-WsizeWidth){1'b0}}, wsize_ff} : 32'd0;

   always_comb begin
      wsize_in = wsize_ff;
      if (csr_write) begin
         wsize_in = pwdata[WsizeWidth-1:0];
      end
   end

   // effective window and the cell where new words enter
   logic [WideW-1:0] wsize_wide;
   logic [WideW-1:0] max_wide;
   logic [WideW-1:0] win_eff;
   logic [WideW-1:0] head_wide;
   logic [IdxW-1:0]  head_tgt;

   assign wsize_wide = WideW'(wsize_ff);
   assign max_wide   = WideW'(MAX_WINDOW);

   always_comb begin
      if (wsize_wide == '0) begin
         win_eff = WideW'(1);
      end else if (wsize_wide > max_wide) begin
         win_eff = max_wide;
      end else begin
         win_eff = wsize_wide;
      end
   end

   assign head_wide = max_wide - win_eff;
   assign head_tgt  = head_wide[IdxW-1:0];

   // head_ff is where the stored words are aligned now
   logic [IdxW-1:0] head_ff;
   logic [IdxW-1:0] head_in;
   logic            shift_up;
   logic            shift_down;
   logic            aligned;

   assign aligned    = (head_ff == head_tgt);
   assign shift_up   = head_tgt > head_ff;
   assign shift_down = head_tgt < head_ff;

   always_comb begin
      head_in = head_ff;
      if (shift_up) begin
         head_in = head_ff + IdxW'(1);
      end else if (shift_down) begin
         head_in = head_ff - IdxW'(1);
      end
   end

   // handshake and fill count
   logic                          take;
   logic [CntW-1:0]               fill_ff;
   logic [CntW-1:0]               fill_in;
   logic [CntW-1:0]               fill_base;
   logic                          emit;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic signed [SampleWidth-1:0] rsp_max_ff;
   logic signed [SampleWidth-1:0] rsp_max_in;

   assign req_ready = aligned && (!rsp_valid_ff || rsp_ready);
   assign take      = req_valid && req_ready;

   always_comb begin
      fill_base = req_restart ? '0 : fill_ff;
      fill_in   = fill_ff;
      if (take) begin
         if (fill_base < CntW'(MAX_WINDOW)) begin
            fill_in = fill_base + CntW'(1);
         end else begin
            fill_in = fill_base;
         end
      end
   end

   assign emit = WideW'(fill_in) >= win_eff;

   // row of cells
   logic signed [SampleWidth-1:0] cell_max  [MAX_WINDOW];
   logic                          cell_live [MAX_WINDOW];
   logic signed [SampleWidth-1:0] cell_next [MAX_WINDOW];

   for (genvar c = 0; c < MAX_WINDOW; c++) begin : g_cell
      swm_ctl_type                   ctl;
      logic signed [SampleWidth-1:0] lo_max;
      logic                          lo_live;
      logic signed [SampleWidth-1:0] hi_max;
      logic                          hi_live;

      assign ctl.step       = take;
      assign ctl.restart    = req_restart;
      assign ctl.shift_up   = shift_up;
      assign ctl.shift_down = shift_down;
      assign ctl.at_head    = (IdxW'(c) == head_ff);
      assign ctl.below_head = (IdxW'(c) < head_ff);

      if (c == 0) begin : g_first
         assign lo_max  = '0;
         assign lo_live = 1'b0;
      end else begin : g_mid
         assign lo_max  = cell_max[c-1];
         assign lo_live = cell_live[c-1];
      end

      // the oldest cell keeps its own total when the row moves back
      if (c == MAX_WINDOW - 1) begin : g_last
         assign hi_max  = cell_max[c];
         assign hi_live = cell_live[c];
      end else begin : g_inner
         assign hi_max  = cell_max[c+1];
         assign hi_live = cell_live[c+1];
      end

      swm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .sample   (req_sample),
         .lo_max   (lo_max),
         .lo_live  (lo_live),
         .hi_max   (hi_max),
         .hi_live  (hi_live),
         .max_out  (cell_max[c]),
         .live_out (cell_live[c]),
         .max_next (cell_next[c])
      );
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_max_in   = rsp_max_ff;
      if (take && emit) begin
         rsp_valid_in = 1'b1;
         rsp_max_in   = cell_next[MAX_WINDOW-1];
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_max_ff <= rsp_max_in;
      if (reset) begin
         wsize_ff     <= WsizeReset;
         head_ff      <= IdxW'(RstHead);
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wsize_ff     <= wsize_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_window_max = rsp_max_ff;

endmodule
